// ===== sv/cqs_pkg.sv =====
// ----------------------------------------------------------------------------
// cqs_pkg
// Operation and status codes, and the command and status bundles that pass
// between the queue controller and the queue datapath.
// ----------------------------------------------------------------------------
package cqs_pkg;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BAD_POS   = 3'd4;

  typedef struct packed {
    logic       load;
    logic       push;
    logic       pop;
    logic       rd_pos;
    logic       srch_start;
    logic       srch_step;
    logic       capture;
    logic       hit;
    logic       st_wr;
    logic [2:0] st_code;
    logic       out_load;
  } cqs_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       pos_ok;
    logic       hit;
    logic       last;
  } cqs_sts_t;

endpackage

// ===== sv/cqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cqs_ctrl
// Sequencer for the queue: latches one beat, runs its operation through the
// datapath and hands the result to the output register.
// ----------------------------------------------------------------------------
module cqs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cqs_pkg::cqs_sts_t sts,
  output cqs_pkg::cqs_cmd_t cmd
);
  import cqs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_PUSH: begin
            if (sts.full) begin
              cmd.st_wr   = 1'b1;
              cmd.st_code = ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
            state_nxt = S_FIN;
          end
          OP_POP: begin
            if (sts.empty) begin
              cmd.st_wr   = 1'b1;
              cmd.st_code = ST_EMPTY;
              state_nxt   = S_FIN;
            end else begin
              cmd.pop   = 1'b1;
              state_nxt = S_WAIT;
            end
          end
          OP_SEARCH: begin
            if (sts.empty) begin
              cmd.st_wr   = 1'b1;
              cmd.st_code = ST_NOT_FOUND;
              state_nxt   = S_FIN;
            end else begin
              cmd.srch_start = 1'b1;
              state_nxt      = S_SRCH;
            end
          end
          default: begin
            if (sts.pos_ok) begin
              cmd.rd_pos = 1'b1;
              state_nxt  = S_WAIT;
            end else begin
              cmd.st_wr   = 1'b1;
              cmd.st_code = ST_BAD_POS;
              state_nxt   = S_FIN;
            end
          end
        endcase
      end
      S_WAIT: begin
        cmd.capture = 1'b1;
        state_nxt   = S_FIN;
      end
      S_SRCH: begin
        if (sts.hit) begin
          cmd.hit     = 1'b1;
          cmd.st_wr   = 1'b1;
          cmd.st_code = ST_OK;
          state_nxt   = S_FIN;
        end else if (sts.last) begin
          cmd.st_wr   = 1'b1;
          cmd.st_code = ST_NOT_FOUND;
          state_nxt   = S_FIN;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/cqs_dp.sv =====
// ----------------------------------------------------------------------------
// cqs_dp
// Queue datapath: slot memory with registered read, head and tail pointers,
// entry count, front and back copies, search walker and result register.
// ----------------------------------------------------------------------------
module cqs_dp #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_operation,
  input  logic [31:0]       in_value,
  input  logic [4:0]        in_position,
  input  cqs_pkg::cqs_cmd_t cmd,
  output cqs_pkg::cqs_sts_t sts,
  output logic [2:0]        out_status,
  output logic [4:0]        out_found_position,
  output logic [31:0]       out_read_value,
  output logic [4:0]        out_count,
  output logic              out_is_empty,
  output logic              out_is_full,
  output logic [31:0]       out_front_value,
  output logic [31:0]       out_back_value
);
  import cqs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic [AW-1:0]         raddr;

  logic [AW-1:0]         head_r, tail_r, ptr_r;
  logic [CW-1:0]         count_r, kc_r;
  logic [1:0]            op_r;
  logic [DATA_WIDTH-1:0] val_r, front_r, back_r, rd_r;
  logic [4:0]            pos_r;
  logic [2:0]            status_r;
  logic [CW-1:0]         found_r;

  logic [XW-1:0]         pos_x, cnt_x;
  logic [CW:0]           sum;
  logic [AW-1:0]         pos_addr;
  logic [AW-1:0]         head_n1, head_n2, tail_n1;
  logic                  empty, full;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign head_n1 = next_idx(head_r);
  assign head_n2 = next_idx(head_n1);
  assign tail_n1 = next_idx(tail_r);
  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));

  assign pos_x    = XW'(pos_r);
  assign cnt_x    = XW'(count_r);
  assign sum      = (CW + 1)'(head_r) + (CW + 1)'(pos_x[CW-1:0]);
  assign pos_addr = (sum >= (CW + 1)'(DEPTH)) ? AW'(sum - (CW + 1)'(DEPTH)) : AW'(sum);

  assign sts.op     = op_r;
  assign sts.full   = full;
  assign sts.empty  = empty;
  assign sts.pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
  assign sts.hit    = (rdata_r == val_r);
  assign sts.last   = (kc_r == count_r);

  always_comb begin
    if (cmd.pop) begin
      raddr = head_n2;
    end else if (cmd.rd_pos) begin
      raddr = pos_addr;
    end else if (cmd.srch_start) begin
      raddr = head_n1;
    end else begin
      raddr = ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_n1] <= val_r;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= AW'(DEPTH - 1);
      tail_r  <= AW'(DEPTH - 1);
      count_r <= '0;
    end else begin
      if (cmd.push) begin
        tail_r  <= tail_n1;
        count_r <= count_r + 1'b1;
      end else if (cmd.pop) begin
        head_r  <= head_n1;
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_operation;
      val_r    <= DATA_WIDTH'(in_value);
      pos_r    <= in_position;
      status_r <= ST_OK;
      found_r  <= '0;
      rd_r     <= '0;
    end
    if (cmd.st_wr) begin
      status_r <= cmd.st_code;
    end
    if (cmd.hit) begin
      found_r <= kc_r;
    end
    if (cmd.push) begin
      back_r <= val_r;
      if (empty) begin
        front_r <= val_r;
      end
    end
    if (cmd.capture) begin
      if (op_r == OP_POP) begin
        front_r <= rdata_r;
      end else begin
        rd_r <= rdata_r;
      end
    end
    if (cmd.srch_start) begin
      ptr_r <= head_n2;
      kc_r  <= CW'(1);
    end else if (cmd.srch_step) begin
      ptr_r <= next_idx(ptr_r);
      kc_r  <= kc_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_status         <= status_r;
      out_found_position <= 5'(found_r);
      out_read_value     <= 32'(rd_r);
      out_count          <= 5'(count_r);
      out_is_empty       <= empty;
      out_is_full        <= full;
      out_front_value    <= empty ? '0 : 32'(front_r);
      out_back_value     <= empty ? '0 : 32'(back_r);
    end
  end

endmodule

// ===== sv/circular_queue_with_search.sv =====
// ----------------------------------------------------------------------------
// circular_queue_with_search
// Ring-buffer queue with push, pop, search and read-at-position operations.
// ----------------------------------------------------------------------------
// Sequence: push and rejected operations go from execute to finish; pop and
//   read pass a wait state for the slot read; search walks up to count slots.
// Throughput: one operation in flight; the next input beat is taken at the
//   result beat at the earliest, and the search walks one slot per cycle.
// Reset: synchronous, active low; queue empties, pointers go to DEPTH-1.
// ----------------------------------------------------------------------------
module circular_queue_with_search #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_value,
  input  logic [4:0]  in_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [4:0]  out_found_position,
  output logic [31:0] out_read_value,
  output logic [4:0]  out_count,
  output logic        out_is_empty,
  output logic        out_is_full,
  output logic [31:0] out_front_value,
  output logic [31:0] out_back_value
);
  import cqs_pkg::*;

  cqs_cmd_t cmd;
  cqs_sts_t sts;

  cqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cqs_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_operation       (in_operation),
    .in_value           (in_value),
    .in_position        (in_position),
    .cmd                (cmd),
    .sts                (sts),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_read_value     (out_read_value),
    .out_count          (out_count),
    .out_is_empty       (out_is_empty),
    .out_is_full        (out_is_full),
    .out_front_value    (out_front_value),
    .out_back_value     (out_back_value)
  );

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an operation is in progress");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.push, cmd.pop, cmd.rd_pos, cmd.srch_start, cmd.srch_step}))
    else $error("more than one datapath action at once");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push |-> !sts.full) and (cmd.pop |-> !sts.empty))
    else $error("push on full or pop on empty queue");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_found_position != 5'd0) |-> (out_status == ST_OK))
    else $error("search position reported without a hit");

endmodule

// ===== dv/cqs_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// cqs_tb_pkg
// Result bundle and scoreboard for the circular queue testbench. The
// scoreboard keeps its own copy of the ring, works out the result of every
// accepted request and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
package cqs_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import cqs_pkg::*;

  localparam int RING_DEPTH = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  found_position;
    logic [31:0] read_value;
    logic [4:0]  count;
    logic        is_empty;
    logic        is_full;
    logic [31:0] front_value;
    logic [31:0] back_value;
  } queue_result_t;

  class queue_scoreboard;
    logic [31:0]   ring_words [RING_DEPTH];
    logic [3:0]    head_pre;
    logic [3:0]    tail_idx;
    logic [4:0]    n_entries;
    queue_result_t expected_results [$];
    int            mismatches;

    function new();
      head_pre   = 4'(RING_DEPTH - 1);
      tail_idx   = 4'(RING_DEPTH - 1);
      n_entries  = '0;
      mismatches = 0;
      foreach (ring_words[i]) ring_words[i] = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] value, logic [4:0] position);
      queue_result_t r;
      logic [3:0]    idx;
      r = '0;
      case (op)
        OP_PUSH: begin
          if (n_entries == 5'(RING_DEPTH)) begin
            r.status = ST_FULL;
          end else begin
            tail_idx = tail_idx + 4'd1;
            ring_words[tail_idx] = value;
            n_entries = n_entries + 5'd1;
          end
        end
        OP_POP: begin
          if (n_entries == 5'd0) begin
            r.status = ST_EMPTY;
          end else begin
            head_pre = head_pre + 4'd1;
            n_entries = n_entries - 5'd1;
          end
        end
        OP_SEARCH: begin
          r.status = ST_NOT_FOUND;
          idx = head_pre;
          for (int k = 1; k <= int'(n_entries); k++) begin
            idx = idx + 4'd1;
            if (r.status == ST_NOT_FOUND && ring_words[idx] == value) begin
              r.status = ST_OK;
              r.found_position = 5'(k);
            end
          end
        end
        default: begin
          if (position >= 5'd1 && position <= n_entries) begin
            idx = head_pre + position[3:0];
            r.read_value = ring_words[idx];
          end else begin
            r.status = ST_BAD_POS;
          end
        end
      endcase
      if (n_entries != 5'd0) begin
        idx = head_pre + 4'd1;
        r.front_value = ring_words[idx];
        r.back_value  = ring_words[tail_idx];
      end
      r.count    = n_entries;
      r.is_empty = (n_entries == 5'd0);
      r.is_full  = (n_entries == 5'(RING_DEPTH));
      expected_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with no request outstanding, expected none, actual %p",
                 $time, got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status",         32'(want.status),         32'(got.status));
      compare_field("found_position", 32'(want.found_position), 32'(got.found_position));
      compare_field("read_value",     want.read_value,          got.read_value);
      compare_field("count",          32'(want.count),          32'(got.count));
      compare_field("is_empty",       32'(want.is_empty),       32'(got.is_empty));
      compare_field("is_full",        32'(want.is_full),        32'(got.is_full));
      compare_field("front_value",    want.front_value,         got.front_value);
      compare_field("back_value",     want.back_value,          got.back_value);
    endfunction
  endclass

endpackage

// ===== dv/tb_circular_queue_with_search.sv =====
// ----------------------------------------------------------------------------
// tb_circular_queue_with_search
// Drives push, pop, search and read-at-position requests into the queue,
// directed corner cases first and then weighted random traffic that swings
// the ring between empty and full, with random idling on both channels, a
// long result back-pressure stretch and a full drain in the middle.
// ----------------------------------------------------------------------------
module tb_circular_queue_with_search;
  timeunit 1ns;
  timeprecision 1ps;

  import cqs_pkg::*;
  import cqs_tb_pkg::*;

  localparam int RANDOM_BEATS = 1550;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = OP_PUSH;
  logic [31:0] in_value = '0;
  logic [4:0]  in_position = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [4:0]  out_found_position;
  logic [31:0] out_read_value;
  logic [4:0]  out_count;
  logic        out_is_empty;
  logic        out_is_full;
  logic [31:0] out_front_value;
  logic [31:0] out_back_value;

  queue_scoreboard sb = new();
  queue_result_t   got;
  bit              idling_on = 1'b1;
  bit              rx_long_hold = 1'b0;
  int              cycle_count = 0;

  circular_queue_with_search u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_read_value     (out_read_value),
    .out_count          (out_count),
    .out_is_empty       (out_is_empty),
    .out_is_full        (out_is_full),
    .out_front_value    (out_front_value),
    .out_back_value     (out_back_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.status         = out_status;
        got.found_position = out_found_position;
        got.read_value     = out_read_value;
        got.count          = out_count;
        got.is_empty       = out_is_empty;
        got.is_full        = out_is_full;
        got.front_value    = out_front_value;
        got.back_value     = out_back_value;
        sb.check_result(got);
      end
      if (in_valid && in_ready) begin
        sb.note_request(in_operation, in_value, in_position);
      end
    end
  end

  task automatic send_beat(logic [1:0] op, logic [31:0] value, logic [4:0] position);
    @(negedge clk);
    in_valid     = 1'b1;
    in_operation = op;
    in_value     = value;
    in_position  = position;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic hold_input(int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    hold_input(1);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // receiver: random ready bursts, random stalls, one long hold on request
  initial begin
    int n;
    wait (rst_n);
    forever begin
      if (rx_long_hold) begin
        rx_long_hold = 1'b0;
        @(negedge clk);
        out_ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        @(negedge clk);
        out_ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        n = $urandom_range(1, 20);
        @(negedge clk);
        out_ready = 1'b1;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin
    logic [31:0] word_pool [8];
    logic [31:0] value;
    logic [4:0]  position;
    logic [1:0]  op;
    int          push_weight;
    int          segment_left;
    int          pick;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty queue: rejected pop, missed search, bad read
    send_beat(OP_POP, 32'h0, 5'd0);
    send_beat(OP_SEARCH, 32'h0, 5'd0);
    send_beat(OP_READ, 32'h0, 5'd0);
    // fill to the brim, then one push too many; then edge reads, a last-slot hit, a miss and a pop
    for (int k = 0; k < RING_DEPTH; k++) begin
      send_beat(OP_PUSH, 32'(k) * 32'h1111_1111, 5'(k));
    end
    send_beat(OP_PUSH, 32'hDEAD_BEEF, 5'd0);
    send_beat(OP_READ, 32'h0, 5'd16);
    send_beat(OP_READ, 32'h0, 5'd17);
    send_beat(OP_SEARCH, 32'hFFFF_FFFF, 5'd0);
    send_beat(OP_SEARCH, 32'h1234_5678, 5'd0);
    send_beat(OP_POP, 32'h0, 5'd0);

    foreach (word_pool[i]) word_pool[i] = $urandom();
    word_pool[0] = 32'h0;
    word_pool[1] = 32'hFFFF_FFFF;
    segment_left = 0;
    push_weight  = 50;

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == 400) rx_long_hold = 1'b1;
      if (i == 800) drain_results();
      if (i == 1300) idling_on = 1'b0;
      if (segment_left == 0) begin
        segment_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       push_weight = 15;
          1:       push_weight = 45;
          default: push_weight = 75;
        endcase
      end
      segment_left--;

      if ($urandom_range(0, 99) < push_weight) begin
        op = OP_PUSH;
      end else begin
        pick = $urandom_range(0, 2);
        op = (pick == 0) ? OP_POP : (pick == 1) ? OP_SEARCH : OP_READ;
      end
      value    = ($urandom_range(0, 2) != 0) ? word_pool[$urandom_range(0, 7)] : $urandom();
      position = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(1, 16))
                                            : 5'($urandom_range(0, 31));

      if (idling_on && $urandom_range(0, 3) == 0) hold_input($urandom_range(1, 10));
      send_beat(op, value, position);
    end

    drain_results();
    repeat (50) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cqs_pkg.sv
sv/cqs_ctrl.sv
sv/cqs_dp.sv
sv/circular_queue_with_search.sv
dv/cqs_tb_pkg.sv
dv/tb_circular_queue_with_search.sv
